### hw/rtl/hse_pkg.sv
// Shared types, constants and command codes of the heap sort engine.
`default_nettype none

package hse_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VAL_W         = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    last_res;
    logic                    overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_EXT_INIT,
    OP_BUILD_RD,
    OP_CUR_LD,
    OP_KID_RD,
    OP_KID_CMP,
    OP_PUT_CUR,
    OP_EXT_RD,
    OP_EXT_SWAP,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic idx_zero;
    logic leaf;
    logic stop;
    logic emit_end;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_BUILD_CHK,
    ST_BUILD_WAIT,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_CHK,
    ST_EXT_SWAP,
    ST_EMIT,
    ST_FLUSH
  } hse_state_t;

endpackage

`default_nettype wire

### hw/rtl/hse_datapath.sv
// Datapath of the heap sort engine: element store, sift registers, counters, result registers.
`default_nettype none

module hse_datapath #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hse_pkg::dp_op_t    op,
  input  hse_pkg::in_item_t  in_item,
  output hse_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output hse_pkg::out_item_t out_item
);
  import hse_pkg::*;

  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int KW    = AW + 2;
  localparam int DEPTH = 1 << AW;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic signed [VAL_W-1:0] rd_a_r, rd_b_r;
  logic signed [VAL_W-1:0] cur_r, cur_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           hsize_r, hsize_nxt;
  logic [AW-1:0]           node_r, node_nxt;
  logic                    drop_r, drop_nxt;
  logic                    emit_v_r, emit_v_nxt;
  logic                    emit_last_r, emit_last_nxt;

  logic [CW-1:0]           idx_dec, idx_inc, fill_dec;
  logic [KW-1:0]           kid_a, kid_b;
  logic                    has_b, sel_b, stop;
  logic signed [VAL_W-1:0] pick_val;
  logic [AW-1:0]           pick_idx;

  logic                    we;
  logic [AW-1:0]           wa, ra, rb;
  logic signed [VAL_W-1:0] wd;

  assign idx_dec  = idx_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign fill_dec = fill_r - CW'(1);
  assign kid_a    = {1'b0, node_r, 1'b1};
  assign kid_b    = kid_a + KW'(1);
  assign has_b    = kid_b < KW'(hsize_r);
  assign sel_b    = has_b && (rd_a_r < rd_b_r);
  assign pick_val = sel_b ? rd_b_r : rd_a_r;
  assign pick_idx = sel_b ? kid_b[AW-1:0] : kid_a[AW-1:0];
  assign stop     = !(cur_r < pick_val);

  assign stat.idx_zero = (idx_r == '0);
  assign stat.leaf     = (kid_a >= KW'(hsize_r));
  assign stat.stop     = stop;
  assign stat.emit_end = (idx_inc == fill_r);

  always_comb begin
    we            = 1'b0;
    wa            = '0;
    wd            = cur_r;
    ra            = '0;
    rb            = '0;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    hsize_nxt     = hsize_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    emit_v_nxt    = 1'b0;
    emit_last_nxt = emit_last_r;
    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        if (fill_r < CW'(MAX_ITEMS)) begin
          we       = 1'b1;
          wa       = fill_r[AW-1:0];
          wd       = in_item.value;
          fill_nxt = fill_r + CW'(1);
        end else begin
          drop_nxt = 1'b1;
        end
      end
      OP_PREP: begin
        idx_nxt   = fill_r >> 1;
        hsize_nxt = fill_r;
      end
      OP_EXT_INIT: begin
        idx_nxt = fill_dec;
      end
      OP_BUILD_RD: begin
        ra      = idx_dec[AW-1:0];
        idx_nxt = idx_dec;
      end
      OP_CUR_LD: begin
        cur_nxt  = rd_a_r;
        node_nxt = idx_r[AW-1:0];
      end
      OP_KID_RD: begin
        ra = kid_a[AW-1:0];
        rb = kid_b[AW-1:0];
      end
      OP_KID_CMP: begin
        we = 1'b1;
        wa = node_r;
        wd = stop ? cur_r : pick_val;
        if (!stop) begin
          node_nxt = pick_idx;
        end
      end
      OP_PUT_CUR: begin
        we = 1'b1;
        wa = node_r;
        wd = cur_r;
      end
      OP_EXT_RD: begin
        ra = '0;
        rb = idx_r[AW-1:0];
      end
      OP_EXT_SWAP: begin
        we        = 1'b1;
        wa        = idx_r[AW-1:0];
        wd        = rd_a_r;
        cur_nxt   = rd_b_r;
        node_nxt  = '0;
        hsize_nxt = idx_r;
        idx_nxt   = idx_dec;
      end
      OP_EMIT_INIT: begin
        idx_nxt = '0;
      end
      OP_EMIT_RD: begin
        ra            = idx_r[AW-1:0];
        idx_nxt       = idx_inc;
        emit_v_nxt    = 1'b1;
        emit_last_nxt = (idx_inc == fill_r);
      end
      OP_CLEAR: begin
        fill_nxt = '0;
        drop_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
    cur_r  <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      hsize_r     <= '0;
      node_r      <= '0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      hsize_r     <= hsize_nxt;
      node_r      <= node_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_last_r <= emit_last_nxt;
    end
  end

  assign out_valid             = emit_v_r;
  assign out_item.sorted_value = rd_a_r;
  assign out_item.last_res     = emit_last_r;
  assign out_item.overflow     = drop_r;

endmodule

`default_nettype wire

### hw/rtl/hse_controller.sv
// Controller state machine of the heap sort engine: load, heap build, extraction, emit.
`default_nettype none

module hse_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_last,
  input  hse_pkg::dp_stat_t stat,
  output logic              busy,
  output hse_pkg::dp_op_t   op
);
  import hse_pkg::*;

  hse_state_t state_r, state_nxt;
  logic       ext_r, ext_nxt;
  hse_state_t sift_ret;

  assign sift_ret = ext_r ? ST_EXT_CHK : ST_BUILD_CHK;
  assign busy     = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ext_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ext_r   <= ext_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ext_nxt   = ext_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          if (in_last) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        op        = OP_PREP;
        ext_nxt   = 1'b0;
        state_nxt = ST_BUILD_CHK;
      end
      ST_BUILD_CHK: begin
        if (stat.idx_zero) begin
          op        = OP_EXT_INIT;
          ext_nxt   = 1'b1;
          state_nxt = ST_EXT_CHK;
        end else begin
          op        = OP_BUILD_RD;
          state_nxt = ST_BUILD_WAIT;
        end
      end
      ST_BUILD_WAIT: begin
        op        = OP_CUR_LD;
        state_nxt = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        if (stat.leaf) begin
          op        = OP_PUT_CUR;
          state_nxt = sift_ret;
        end else begin
          op        = OP_KID_RD;
          state_nxt = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: begin
        op        = OP_KID_CMP;
        state_nxt = stat.stop ? sift_ret : ST_SIFT_RD;
      end
      ST_EXT_CHK: begin
        if (stat.idx_zero) begin
          op        = OP_EMIT_INIT;
          state_nxt = ST_EMIT;
        end else begin
          op        = OP_EXT_RD;
          state_nxt = ST_EXT_SWAP;
        end
      end
      ST_EXT_SWAP: begin
        op        = OP_EXT_SWAP;
        state_nxt = ST_SIFT_RD;
      end
      ST_EMIT: begin
        op = OP_EMIT_RD;
        if (stat.emit_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        op        = OP_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/heap_sort_engine.sv
// Top level of the heap sort engine.
// Each element is loaded while busy is low, and busy stays low after a non-final one.
// The element marked last ends the set; busy then stays high while the set of n
// stored elements is heap-sorted in the single element store and emitted. Each
// sift level reads both children, then compares and writes, on the store's two
// read ports and one write port. After sorting, the first element is read and a
// burst of n results follows on consecutive cycles; busy falls right after the
// final result. The receiver cannot stall: each result is valid for exactly one
// cycle while out_valid is high. Elements beyond MAX_ITEMS are dropped and every
// result of that set carries overflow.
`default_nettype none

module heap_sort_engine #(
  parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hse_pkg::in_item_t  in_item,
  output logic               out_valid,
  output hse_pkg::out_item_t out_item
);
  import hse_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  hse_controller u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_item.last),
    .stat    (stat),
    .busy    (busy),
    .op      (op)
  );

  hse_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### hw/rtl/hse_checker.sv
// Port-level checker of the heap sort engine and its bind to the top level.
`default_nettype none

module hse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input hse_pkg::in_item_t  in_item,
  input logic               out_valid,
  input hse_pkg::out_item_t out_item
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("engine not idle after reset");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transfer while idle");

  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_item.last |=> !busy && !out_valid)
    else $error("non-final transfer did not return to idle");

  a_last_sorts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.last |=> busy)
    else $error("final transfer did not start sorting");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_res |=> !out_valid)
    else $error("result after final result");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

### test/heap_sort_engine_tb.sv
// Self-checking testbench for heap_sort_engine: directed and random sets against a sort predictor.
module heap_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hse_pkg::*;

  localparam int CAP          = MAX_ITEMS_DEF;
  localparam int RAND_ITEMS   = 370;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 50;
  localparam int DIR_ROWS     = 16;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  logic signed [VAL_W-1:0] held [CAP];
  int                      held_cnt = 0;
  logic                    held_dropped = 1'b0;
  out_item_t               sorted_q [$];
  out_item_t               got_exp;
  dir_row_t                dir_rows [DIR_ROWS];
  int                      errors = 0;
  int                      cycles = 0;

  heap_sort_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("heap_sort_engine_tb NOT OK");
      $finish;
    end
  end

  function automatic dir_row_t mk_row(logic signed [VAL_W-1:0] v, logic l, logic t,
                                      logic signed [VAL_W-1:0] ev);
    dir_row_t r;
    r.item.value       = v;
    r.item.last        = l;
    r.typed            = t;
    r.res.sorted_value = ev;
    r.res.last_res     = 1'b1;
    r.res.overflow     = 1'b0;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // store the element, and on the set's end sort and queue the burst
  task automatic take_element(input in_item_t it, input logic typed, input out_item_t res);
    logic signed [VAL_W-1:0] t;
    int                      j;
    out_item_t               r;
    if (held_cnt < CAP) begin
      held[held_cnt] = it.value;
      held_cnt++;
    end else begin
      held_dropped = 1'b1;
    end
    if (it.last) begin
      for (int i = 1; i < held_cnt; i++) begin
        t = held[i];
        j = i - 1;
        while (j >= 0 && held[j] > t) begin
          held[j + 1] = held[j];
          j--;
        end
        held[j + 1] = t;
      end
      for (int k = 0; k < held_cnt; k++) begin
        r.sorted_value = held[k];
        r.last_res     = (k == held_cnt - 1);
        r.overflow     = held_dropped;
        sorted_q.push_back(typed ? res : r);
      end
      held_cnt     = 0;
      held_dropped = 1'b0;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_element(input in_item_t it, input int gap, input logic typed,
                              input out_item_t res);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    take_element(it, typed, res);
    @(negedge clk);
  endtask

  task automatic send_set(input int n);
    in_item_t it;
    logic     quiet;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      it.value = rand_value();
      it.last  = (i == n - 1);
      send_element(it, quiet ? 0 : $urandom_range(0, 19), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        got_exp = sorted_q.pop_front();
        if (out_item.sorted_value !== got_exp.sorted_value) begin
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d", $time,
                   got_exp.sorted_value, out_item.sorted_value);
          errors++;
        end
        if (out_item.last_res !== got_exp.last_res) begin
          $display("%0t: last_res mismatch: expected %b, actual %b", $time,
                   got_exp.last_res, out_item.last_res);
          errors++;
        end
        if (out_item.overflow !== got_exp.overflow) begin
          $display("%0t: overflow mismatch: expected %b, actual %b", $time,
                   got_exp.overflow, out_item.overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    int sent;
    int n;
    dir_rows = '{
      mk_row(32'sd0, 1'b1, 1'b1, 32'sd0),
      mk_row(32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff),
      mk_row(32'h80000000, 1'b1, 1'b1, 32'h80000000),
      mk_row(32'sd5, 1'b0, 1'b0, 32'sd0),
      mk_row(-32'sd5, 1'b1, 1'b0, 32'sd0),
      mk_row(32'h7fffffff, 1'b0, 1'b0, 32'sd0),
      mk_row(32'h80000000, 1'b0, 1'b0, 32'sd0),
      mk_row(32'sd0, 1'b0, 1'b0, 32'sd0),
      mk_row(-32'sd1, 1'b0, 1'b0, 32'sd0),
      mk_row(32'sd1, 1'b0, 1'b0, 32'sd0),
      mk_row(32'h80000000, 1'b1, 1'b0, 32'sd0),
      mk_row(32'sd3, 1'b0, 1'b0, 32'sd0),
      mk_row(32'sd3, 1'b0, 1'b0, 32'sd0),
      mk_row(32'sd3, 1'b1, 1'b0, 32'sd0),
      mk_row(32'haaaaaaaa, 1'b0, 1'b0, 32'sd0),
      mk_row(32'h55555555, 1'b1, 1'b0, 32'sd0)
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_element(dir_rows[i].item, $urandom_range(0, 19), dir_rows[i].typed, dir_rows[i].res);

    // hold off until the directed sets have drained
    start <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);

    send_set(CAP);
    send_set(CAP + 1);
    sent = 2 * CAP + 1;
    while (sent < RAND_ITEMS) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(CAP + 2, CAP + 8)
                                       : $urandom_range(1, 12);
      send_set(n);
      sent += n;
    end
    start <= 1'b0;

    while (sorted_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("heap_sort_engine_tb OK");
    end else begin
      $display("heap_sort_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hse_pkg.sv
hw/rtl/hse_datapath.sv
hw/rtl/hse_controller.sv
hw/rtl/heap_sort_engine.sv
hw/rtl/hse_checker.sv
test/heap_sort_engine_tb.sv
